// File: hw/rtl/gle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_pkg
// Shared constants, types and arithmetic helpers for the geodetic to local
// ENU converter: CORDIC tables, WGS84 constants and rounding products.
// ----------------------------------------------------------------------------
package gle_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int FRAC_BITS    = 30;
   localparam int TAB_LEN      = 48;
   localparam int NSTEPS       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

   // datapath widths
   localparam int TRW  = FRAC_BITS + 3;          // trig values, signed Q(F)
   localparam int ZW   = FRAC_BITS + 3;          // CORDIC angle accumulator
   localparam int PRW  = 2 * FRAC_BITS + 4;      // trig by trig product magnitude
   localparam int PW   = 80;                     // general product magnitude
   localparam int RW   = 48;                     // rounded product, signed
   localparam int WW   = FRAC_BITS + 1;          // ellipsoid term and its root
   localparam int SQW  = 2 * FRAC_BITS + 3;      // square root remainder
   localparam int QB   = 34;                     // quotient bits of the radius divide
   localparam int RMW  = WW + 1;                 // divider remainder
   localparam int E2W  = FRAC_BITS - 6;          // e2 in Q(F)
   localparam int CW   = 40;                     // earth-centred coordinates
   localparam int DW   = 41;                     // difference to reference point
   localparam int OW   = 35;                     // result fields

   // latency of the angle unit: reduction, two product stages, steps, quadrant
   localparam int SC_LAT = NSTEPS + 4;

   // constants, all worked out at elaboration
   localparam logic [127:0] PI_Q60   = 128'h3243F6A8885A308D;
   localparam logic [127:0] GAIN_NUM = 128'd607252935008881256;
   localparam logic [127:0] E2_NUM   = 128'd6694379990140000;
   localparam logic [127:0] DEC_DEN  = 128'd1000000000000000000;
   localparam logic [127:0] ANG_K    = ((PI_Q60 << 31) / 128'd1800000000 + 128'd1) >> 1;
   localparam logic [127:0] GAIN_Q   =
      ((GAIN_NUM << (FRAC_BITS + 1)) / DEC_DEN + 128'd1) >> 1;
   localparam logic [127:0] E2_Q     =
      ((E2_NUM << (FRAC_BITS + 1)) / DEC_DEN + 128'd1) >> 1;
   localparam logic [127:0] NUM2     = 128'd6378137000 << (FRAC_BITS + 1);

   typedef logic signed [TRW-1:0] trig_type;
   typedef logic [ZW-1:0] atan_arr_type [TAB_LEN];

   // values that ride alongside the radius pipeline
   typedef struct packed {
      logic signed [24:0] height;
      trig_type           sp;
      trig_type           cpcl;
      trig_type           cpsl;
      trig_type           c0;
      trig_type           s0;
      trig_type           cg;
      trig_type           sg;
      trig_type           s0cg;
      trig_type           s0sg;
      trig_type           c0cg;
      trig_type           c0sg;
   } side_type;

   // truncating quotient of two positive constants, long division
   function automatic longint cdiv(input longint num, input longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((num >>> b) & 64'sd1);
         q = q <<< 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'sd1;
         end
      end
      return q;
   endfunction

   // arctangent table from the Taylor series in Q62, rounded to Q(F)
   function automatic atan_arr_type build_atan();
      atan_arr_type tab;
      longint       v;
      longint       t;
      int           e;
      for (int i = 0; i < TAB_LEN; i++) begin
         if (i == 0) begin
            v = longint'(PI_Q60[63:0]);
         end else begin
            v = 0;
            for (int k = 0; k < 32; k++) begin
               e = i * (2 * k + 1);
               if (e <= 62) begin
                  t = cdiv(64'sd1 <<< (62 - e), longint'(2 * k + 1));
                  v = ((k & 1) == 1) ? v - t : v + t;
               end
            end
         end
         tab[i] = ZW'((v + (64'sd1 <<< (61 - FRAC_BITS))) >>> (62 - FRAC_BITS));
      end
      return tab;
   endfunction

   localparam atan_arr_type ATAN_TAB = build_atan();

   // magnitude of a trig value
   function automatic logic [FRAC_BITS+1:0] tmag(input trig_type v);
      return v[TRW-1] ? (FRAC_BITS+2)'(-v) : v[FRAC_BITS+1:0];
   endfunction

   // magnitude of a wide signed value
   function automatic logic [RW-1:0] wmag(input logic signed [RW-1:0] v);
      return v[RW-1] ? RW'(-v) : RW'(v);
   endfunction

   // round a product magnitude half away from zero to Q(F) and apply sign
   function automatic logic signed [RW-1:0] rnd_mul(input logic [PW-1:0] m,
                                                     input logic neg);
      logic [PW-1:0] r;
      r = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -$signed(r[RW-1:0]) : $signed(r[RW-1:0]);
   endfunction

endpackage

// File: hw/rtl/gle_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_sincos
// Pipelined cosine and sine of an angle in 1e-7 degree: quadrant reduction,
// conversion to radians, one CORDIC rotation per stage, quadrant rotation.
// ----------------------------------------------------------------------------
module gle_sincos (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] angle,
   output logic               out_valid,
   output gle_pkg::trig_type  co,
   output gle_pkg::trig_type  si
);
   import gle_pkg::*;

   localparam logic signed [33:0] QTR   = 34'sd900000000;
   localparam logic signed [33:0] HALFQ = 34'sd450000000;
   localparam logic signed [33:0] TWOQ  = 34'sd1800000000;
   localparam int SH = 90 - FRAC_BITS;

   logic signed [33:0] t_w, off_w, d_w;
   logic [1:0]         quad_w;
   logic [28:0]        mag_w;

   // quadrant reduction, exact in integer units
   always_comb begin
      t_w = 34'(angle) + HALFQ;
      priority if (t_w >= TWOQ) begin
         quad_w = 2'd2;
         off_w  = TWOQ;
      end else if (t_w >= QTR) begin
         quad_w = 2'd1;
         off_w  = QTR;
      end else if (t_w >= 34'sd0) begin
         quad_w = 2'd0;
         off_w  = '0;
      end else if (t_w >= -QTR) begin
         quad_w = 2'd3;
         off_w  = -QTR;
      end else begin
         quad_w = 2'd2;
         off_w  = -TWOQ;
      end
      d_w   = 34'(angle) - off_w;
      mag_w = d_w[33] ? 29'(-d_w) : d_w[28:0];
   end

   logic        v0_ff, neg0_ff;
   logic [1:0]  q0_ff;
   logic [28:0] mag0_ff;
   logic        v1_ff, neg1_ff;
   logic [1:0]  q1_ff;
   logic [60:0] plo_ff, phi_ff;
   logic        v2_ff;
   logic [1:0]  q2_ff;
   logic signed [ZW-1:0] z2_ff;

   logic [92:0]    sum_w, zr_w;
   logic [ZW-1:0]  zmag_w;

   // radians: |d| * K / 2^(90-F), rounded
   always_comb begin
      sum_w  = {phi_ff, 32'b0} + 93'(plo_ff);
      zr_w   = sum_w + (93'd1 << (SH - 1));
      zmag_w = zr_w[SH +: ZW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (en) begin
         neg0_ff <= d_w[33];
         q0_ff   <= quad_w;
         mag0_ff <= mag_w;
         neg1_ff <= neg0_ff;
         q1_ff   <= q0_ff;
         plo_ff  <= 61'(mag0_ff) * ANG_K[31:0];
         phi_ff  <= 61'(mag0_ff) * ANG_K[63:32];
         q2_ff   <= q1_ff;
         z2_ff   <= neg1_ff ? -$signed(zmag_w) : $signed(zmag_w);
      end
   end

   // CORDIC rotation, one step per stage
   logic signed [TRW-1:0] cx_ff [1:NSTEPS];
   logic signed [TRW-1:0] cy_ff [1:NSTEPS];
   logic signed [ZW-1:0]  cz_ff [1:NSTEPS];
   logic [1:0]            cq_ff [1:NSTEPS];
   logic                  cv_ff [1:NSTEPS];

   for (genvar i = 0; i < NSTEPS; i++) begin : g_step
      logic signed [TRW-1:0] xi, yi;
      logic signed [ZW-1:0]  zi;
      logic [1:0]            qi;
      logic                  vi;
      if (i == 0) begin : g_first
         assign xi = TRW'(GAIN_Q);
         assign yi = '0;
         assign zi = z2_ff;
         assign qi = q2_ff;
         assign vi = v2_ff;
      end else begin : g_next
         assign xi = cx_ff[i];
         assign yi = cy_ff[i];
         assign zi = cz_ff[i];
         assign qi = cq_ff[i];
         assign vi = cv_ff[i];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= vi;
         end
         if (en) begin
            cq_ff[i+1] <= qi;
            if (!zi[ZW-1]) begin
               cx_ff[i+1] <= xi - (yi >>> i);
               cy_ff[i+1] <= yi + (xi >>> i);
               cz_ff[i+1] <= zi - $signed(ATAN_TAB[i]);
            end else begin
               cx_ff[i+1] <= xi + (yi >>> i);
               cy_ff[i+1] <= yi - (xi >>> i);
               cz_ff[i+1] <= zi + $signed(ATAN_TAB[i]);
            end
         end
      end
   end

   // quarter-turn rotation of the residual pair
   trig_type co_in, si_in, co_ff, si_ff;
   logic     ov_ff;

   always_comb begin
      unique case (cq_ff[NSTEPS])
         2'd0: begin
            co_in = cx_ff[NSTEPS];
            si_in = cy_ff[NSTEPS];
         end
         2'd1: begin
            co_in = -cy_ff[NSTEPS];
            si_in = cx_ff[NSTEPS];
         end
         2'd2: begin
            co_in = -cx_ff[NSTEPS];
            si_in = -cy_ff[NSTEPS];
         end
         default: begin
            co_in = cy_ff[NSTEPS];
            si_in = -cx_ff[NSTEPS];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= cv_ff[NSTEPS];
      end
      if (en) begin
         co_ff <= co_in;
         si_ff <= si_in;
      end
   end

   assign out_valid = ov_ff;
   assign co        = co_ff;
   assign si        = si_ff;

endmodule

// File: hw/rtl/gle_radius.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_radius
// Prime-vertical radius pipeline: square root of the ellipsoid term one bit
// per stage, then a restoring divide of a*2^(F+1) one quotient bit per stage.
// ----------------------------------------------------------------------------
module gle_radius (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [gle_pkg::WW-1:0]    w,
   input  gle_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [gle_pkg::QB-1:0]    quot,
   output gle_pkg::side_type         out_side
);
   import gle_pkg::*;

   // square root stages
   logic [SQW-1:0] rem_ff [1:WW];
   logic [WW-1:0]  res_ff [1:WW];
   side_type       sside_ff [1:WW];
   logic           sv_ff [1:WW];

   for (genvar j = 0; j < WW; j++) begin : g_sqrt
      localparam int B = FRAC_BITS - j;
      logic [SQW-1:0] remi, trial;
      logic [WW-1:0]  resi;
      side_type       sidei;
      logic           vi;
      if (j == 0) begin : g_first
         assign remi  = SQW'(w) << FRAC_BITS;
         assign resi  = '0;
         assign sidei = in_side;
         assign vi    = in_valid;
      end else begin : g_next
         assign remi  = rem_ff[j];
         assign resi  = res_ff[j];
         assign sidei = sside_ff[j];
         assign vi    = sv_ff[j];
      end
      assign trial = (SQW'(resi) << (B + 1)) | (SQW'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j+1] <= 1'b0;
         end else if (en) begin
            sv_ff[j+1] <= vi;
         end
         if (en) begin
            sside_ff[j+1] <= sidei;
            if (remi >= trial) begin
               rem_ff[j+1] <= remi - trial;
               res_ff[j+1] <= resi | (WW'(1) << B);
            end else begin
               rem_ff[j+1] <= remi;
               res_ff[j+1] <= resi;
            end
         end
      end
   end

   // divide stages
   logic [RMW-1:0] drem_ff [1:QB];
   logic [WW-1:0]  den_ff  [1:QB];
   logic [QB-1:0]  q_ff    [1:QB];
   side_type       dside_ff [1:QB];
   logic           dv_ff [1:QB];

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [RMW-1:0] dremi, r2;
      logic [WW-1:0]  deni;
      logic [QB-1:0]  qi;
      side_type       sidei;
      logic           vi;
      if (k == 0) begin : g_first
         assign dremi = RMW'(NUM2 >> QB);
         assign deni  = (res_ff[WW] == '0) ? WW'(1) : res_ff[WW];
         assign qi    = '0;
         assign sidei = sside_ff[WW];
         assign vi    = sv_ff[WW];
      end else begin : g_next
         assign dremi = drem_ff[k];
         assign deni  = den_ff[k];
         assign qi    = q_ff[k];
         assign sidei = dside_ff[k];
         assign vi    = dv_ff[k];
      end
      assign r2 = {dremi[RMW-2:0], NUM2[QB-1-k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= vi;
         end
         if (en) begin
            den_ff[k+1]   <= deni;
            dside_ff[k+1] <= sidei;
            if (r2 >= {1'b0, deni}) begin
               drem_ff[k+1] <= r2 - {1'b0, deni};
               q_ff[k+1]    <= {qi[QB-2:0], 1'b1};
            end else begin
               drem_ff[k+1] <= r2;
               q_ff[k+1]    <= {qi[QB-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = dv_ff[QB];
   assign quot      = q_ff[QB];
   assign out_side  = dside_ff[QB];

endmodule

// File: hw/rtl/geodetic_to_local_enu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// WGS84 geodetic position to earth-centred or local east/north/up, in mm.
// ----------------------------------------------------------------------------
// One position enters per clock while the pipeline is not held, and one result leaves per position, in order.
// The pipeline is the sine/cosine units, the product stages P1 to P4,
// FRAC_BITS + 1 square root stages, 34 divide stages, five product
// stages P5 to P9 and the output register.
// The whole pipeline holds when a result waits at the output and the last
// stage is full; reference point and frame are read from the registers as
// items pass, so write them only while no transaction is in flight.
module geodetic_to_local_enu (
   input  logic          clock,
   input  logic          reset,
   // latitude[30:0], longitude[62:31], height[87:63]
   input  logic [87:0]   req_tdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // coord_first[34:0], coord_second[69:35], coord_third[104:70], zero pad
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [5:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import gle_pkg::*;

   typedef enum logic [2:0] {
      REG_FRAME   = 3'd0,
      REG_REF_X   = 3'd1,
      REG_REF_Y   = 3'd2,
      REG_REF_Z   = 3'd3,
      REG_REF_LAT = 3'd4,
      REG_REF_LON = 3'd5
   } csr_index_type;

   // configuration registers
   logic                frame_ff;
   logic signed [33:0]  ref_x_ff, ref_y_ff, ref_z_ff;
   logic signed [30:0]  ref_lat_ff;
   logic signed [31:0]  ref_lon_ff;
   csr_index_type       csr_idx;
   logic                csr_wr;

   assign csr_idx    = csr_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= 1'b0;
         ref_x_ff   <= '0;
         ref_y_ff   <= '0;
         ref_z_ff   <= '0;
         ref_lat_ff <= '0;
         ref_lon_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME:   frame_ff   <= csr_pwdata[0];
            REG_REF_X:   ref_x_ff   <= csr_pwdata[33:0];
            REG_REF_Y:   ref_y_ff   <= csr_pwdata[33:0];
            REG_REF_Z:   ref_z_ff   <= csr_pwdata[33:0];
            REG_REF_LAT: ref_lat_ff <= csr_pwdata[30:0];
            REG_REF_LON: ref_lon_ff <= csr_pwdata[31:0];
            default:     ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_FRAME:   csr_prdata = {63'b0, frame_ff};
         REG_REF_X:   csr_prdata = {30'b0, ref_x_ff};
         REG_REF_Y:   csr_prdata = {30'b0, ref_y_ff};
         REG_REF_Z:   csr_prdata = {30'b0, ref_z_ff};
         REG_REF_LAT: csr_prdata = {33'b0, ref_lat_ff};
         REG_REF_LON: csr_prdata = {32'b0, ref_lon_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // flow control: everything moves together
   logic adv, out_load, v9_ff, rsp_tvalid_ff;
   logic [111:0] rsp_tdata_ff;

   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign adv        = out_load || !v9_ff;
   assign req_tready = adv;

   logic signed [30:0] in_lat;
   logic signed [31:0] in_lon;
   logic signed [24:0] in_h;

   assign in_lat = req_tdata[30:0];
   assign in_lon = req_tdata[62:31];
   assign in_h   = req_tdata[87:63];

   // sine and cosine of the point and of the reference
   logic     vl_a, vl_b, vl_c, vl_d;
   trig_type cp, sp, cl, sl, c0, s0, cg, sg;

   gle_sincos u_sc_lat (
      .clock, .reset, .en(adv), .in_valid(req_tvalid),
      .angle(32'(in_lat)), .out_valid(vl_a), .co(cp), .si(sp)
   );
   gle_sincos u_sc_lon (
      .clock, .reset, .en(adv), .in_valid(req_tvalid),
      .angle(in_lon), .out_valid(vl_b), .co(cl), .si(sl)
   );
   gle_sincos u_sc_rlat (
      .clock, .reset, .en(adv), .in_valid(req_tvalid),
      .angle(32'(ref_lat_ff)), .out_valid(vl_c), .co(c0), .si(s0)
   );
   gle_sincos u_sc_rlon (
      .clock, .reset, .en(adv), .in_valid(req_tvalid),
      .angle(ref_lon_ff), .out_valid(vl_d), .co(cg), .si(sg)
   );

   // height rides beside the angle pipeline
   logic signed [24:0] h_dly_ff [0:SC_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         h_dly_ff[0] <= in_h;
         for (int i = 1; i < SC_LAT; i++) begin
            h_dly_ff[i] <= h_dly_ff[i-1];
         end
      end
   end

   // P1: trig products
   logic               v1_ff;
   logic [PRW-1:0]     p_sp2_ff, p_cpcl_ff, p_cpsl_ff;
   logic [PRW-1:0]     p_s0cg_ff, p_s0sg_ff, p_c0cg_ff, p_c0sg_ff;
   logic               n_cpcl_ff, n_cpsl_ff, n_s0cg_ff, n_s0sg_ff, n_c0cg_ff, n_c0sg_ff;
   trig_type           sp1_ff, c01_ff, s01_ff, cg1_ff, sg1_ff;
   logic signed [24:0] h1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= vl_a && vl_b && vl_c && vl_d;
      end
      if (adv) begin
         p_sp2_ff  <= PRW'(tmag(sp)) * tmag(sp);
         p_cpcl_ff <= PRW'(tmag(cp)) * tmag(cl);
         p_cpsl_ff <= PRW'(tmag(cp)) * tmag(sl);
         p_s0cg_ff <= PRW'(tmag(s0)) * tmag(cg);
         p_s0sg_ff <= PRW'(tmag(s0)) * tmag(sg);
         p_c0cg_ff <= PRW'(tmag(c0)) * tmag(cg);
         p_c0sg_ff <= PRW'(tmag(c0)) * tmag(sg);
         n_cpcl_ff <= cp[TRW-1] ^ cl[TRW-1];
         n_cpsl_ff <= cp[TRW-1] ^ sl[TRW-1];
         n_s0cg_ff <= s0[TRW-1] ^ cg[TRW-1];
         n_s0sg_ff <= s0[TRW-1] ^ sg[TRW-1];
         n_c0cg_ff <= c0[TRW-1] ^ cg[TRW-1];
         n_c0sg_ff <= c0[TRW-1] ^ sg[TRW-1];
         sp1_ff    <= sp;
         c01_ff    <= c0;
         s01_ff    <= s0;
         cg1_ff    <= cg;
         sg1_ff    <= sg;
         h1_ff     <= h_dly_ff[SC_LAT-1];
      end
   end

   // P2: rounding of the trig products
   logic     v2_ff;
   trig_type s2_ff;
   side_type side2_ff, side2_in;

   always_comb begin
      side2_in.height = h1_ff;
      side2_in.sp     = sp1_ff;
      side2_in.cpcl   = TRW'(rnd_mul(PW'(p_cpcl_ff), n_cpcl_ff));
      side2_in.cpsl   = TRW'(rnd_mul(PW'(p_cpsl_ff), n_cpsl_ff));
      side2_in.c0     = c01_ff;
      side2_in.s0     = s01_ff;
      side2_in.cg     = cg1_ff;
      side2_in.sg     = sg1_ff;
      side2_in.s0cg   = TRW'(rnd_mul(PW'(p_s0cg_ff), n_s0cg_ff));
      side2_in.s0sg   = TRW'(rnd_mul(PW'(p_s0sg_ff), n_s0sg_ff));
      side2_in.c0cg   = TRW'(rnd_mul(PW'(p_c0cg_ff), n_c0cg_ff));
      side2_in.c0sg   = TRW'(rnd_mul(PW'(p_c0sg_ff), n_c0sg_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         s2_ff    <= TRW'(rnd_mul(PW'(p_sp2_ff), 1'b0));
         side2_ff <= side2_in;
      end
   end

   // P3: e2 * sin^2
   logic          v3_ff;
   logic [PW-1:0] e2p_ff;
   side_type      side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         e2p_ff   <= PW'(s2_ff[FRAC_BITS+1:0]) * E2_Q[E2W-1:0];
         side3_ff <= side2_ff;
      end
   end

   // P4: ellipsoid term w = 1 - e2 sin^2, never below one lsb
   logic                 v4_ff;
   logic [WW-1:0]        w_ff;
   side_type             side4_ff;
   logic signed [RW-1:0] w_w;

   assign w_w = (RW'(1) <<< FRAC_BITS) - rnd_mul(e2p_ff, 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         w_ff     <= (w_w < RW'(1)) ? WW'(1) : w_w[WW-1:0];
         side4_ff <= side3_ff;
      end
   end

   // radius: square root and divide
   logic          vr;
   logic [QB-1:0] quot;
   side_type      sider;

   gle_radius u_radius (
      .clock, .reset, .en(adv), .in_valid(v4_ff), .w(w_ff), .in_side(side4_ff),
      .out_valid(vr), .quot, .out_side(sider)
   );

   // P5: N, N+h and N*e2
   logic                 v5_ff;
   logic [QB-1:0]        n_w;
   logic [QB:0]          nr_w;
   logic [QB-1:0]        n5_ff;
   logic signed [RW-1:0] nh5_ff;
   logic [PW-1:0]        ne2_ff;
   side_type             side5_ff;

   assign nr_w = ({1'b0, quot} + (QB+1)'(1)) >> 1;
   assign n_w  = nr_w[QB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= vr;
      end
      if (adv) begin
         n5_ff    <= n_w;
         nh5_ff   <= $signed(RW'(n_w)) + RW'(sider.height);
         ne2_ff   <= PW'(n_w) * E2_Q[E2W-1:0];
         side5_ff <= sider;
      end
   end

   // P6: N(1-e2)+h
   logic                 v6_ff;
   logic signed [RW-1:0] nh6_ff, zf6_ff;
   side_type             side6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         nh6_ff   <= nh5_ff;
         zf6_ff   <= $signed(RW'(n5_ff)) - rnd_mul(ne2_ff, 1'b0)
                     + RW'(side5_ff.height);
         side6_ff <= side5_ff;
      end
   end

   // P7: earth-centred products
   logic          v7_ff;
   logic [PW-1:0] px_ff, py_ff, pz_ff;
   logic          nx_ff, ny_ff, nz_ff;
   side_type      side7_ff;
   logic [RW-1:0] nh_mag, zf_mag;

   assign nh_mag = wmag(nh6_ff);
   assign zf_mag = wmag(zf6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
      if (adv) begin
         px_ff    <= PW'(nh_mag[35:0]) * tmag(side6_ff.cpcl);
         py_ff    <= PW'(nh_mag[35:0]) * tmag(side6_ff.cpsl);
         pz_ff    <= PW'(zf_mag[35:0]) * tmag(side6_ff.sp);
         nx_ff    <= nh6_ff[RW-1] ^ side6_ff.cpcl[TRW-1];
         ny_ff    <= nh6_ff[RW-1] ^ side6_ff.cpsl[TRW-1];
         nz_ff    <= zf6_ff[RW-1] ^ side6_ff.sp[TRW-1];
         side7_ff <= side6_ff;
      end
   end

   // P8: x, y, z and difference to the reference point
   logic                 v8_ff;
   logic signed [CW-1:0] x8_ff, y8_ff, z8_ff;
   logic signed [DW-1:0] dx8_ff, dy8_ff, dz8_ff;
   side_type             side8_ff;
   logic signed [CW-1:0] x_w, y_w, z_w;

   assign x_w = CW'(rnd_mul(px_ff, nx_ff));
   assign y_w = CW'(rnd_mul(py_ff, ny_ff));
   assign z_w = CW'(rnd_mul(pz_ff, nz_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
      if (adv) begin
         x8_ff    <= x_w;
         y8_ff    <= y_w;
         z8_ff    <= z_w;
         dx8_ff   <= DW'(x_w) - DW'(ref_x_ff);
         dy8_ff   <= DW'(y_w) - DW'(ref_y_ff);
         dz8_ff   <= DW'(z_w) - DW'(ref_z_ff);
         side8_ff <= side7_ff;
      end
   end

   // P9: rotation products
   logic [PW-1:0] pe1_ff, pe2_ff, pn1_ff, pn2_ff, pn3_ff, pu1_ff, pu2_ff, pu3_ff;
   logic          ne1_ff, ne2s_ff, nn1_ff, nn2_ff, nn3_ff, nu1_ff, nu2_ff, nu3_ff;
   logic signed [CW-1:0] x9_ff, y9_ff, z9_ff;
   logic [RW-1:0] dxm, dym, dzm;
   logic          sx, sy, sz;

   assign dxm = wmag(RW'(dx8_ff));
   assign dym = wmag(RW'(dy8_ff));
   assign dzm = wmag(RW'(dz8_ff));
   assign sx  = dx8_ff[DW-1];
   assign sy  = dy8_ff[DW-1];
   assign sz  = dz8_ff[DW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= v8_ff;
      end
      if (adv) begin
         pe1_ff  <= PW'(dxm[DW-1:0]) * tmag(side8_ff.sg);
         pe2_ff  <= PW'(dym[DW-1:0]) * tmag(side8_ff.cg);
         pn1_ff  <= PW'(dxm[DW-1:0]) * tmag(side8_ff.s0cg);
         pn2_ff  <= PW'(dym[DW-1:0]) * tmag(side8_ff.s0sg);
         pn3_ff  <= PW'(dzm[DW-1:0]) * tmag(side8_ff.c0);
         pu1_ff  <= PW'(dxm[DW-1:0]) * tmag(side8_ff.c0cg);
         pu2_ff  <= PW'(dym[DW-1:0]) * tmag(side8_ff.c0sg);
         pu3_ff  <= PW'(dzm[DW-1:0]) * tmag(side8_ff.s0);
         ne1_ff  <= sx ^ side8_ff.sg[TRW-1];
         ne2s_ff <= sy ^ side8_ff.cg[TRW-1];
         nn1_ff  <= sx ^ side8_ff.s0cg[TRW-1];
         nn2_ff  <= sy ^ side8_ff.s0sg[TRW-1];
         nn3_ff  <= sz ^ side8_ff.c0[TRW-1];
         nu1_ff  <= sx ^ side8_ff.c0cg[TRW-1];
         nu2_ff  <= sy ^ side8_ff.c0sg[TRW-1];
         nu3_ff  <= sz ^ side8_ff.s0[TRW-1];
         x9_ff   <= x8_ff;
         y9_ff   <= y8_ff;
         z9_ff   <= z8_ff;
      end
   end

   // saturate to the 35-bit result range
   function automatic logic [OW-1:0] sat_out(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] hi, lo;
      hi = RW'(35'sh3FFFFFFFF);
      lo = -hi - RW'(1);
      if (v > hi) begin
         return OW'(hi);
      end else if (v < lo) begin
         return OW'(lo);
      end
      return v[OW-1:0];
   endfunction

   // P10: sum the rounded terms, pick the frame
   logic signed [RW-1:0] o1_w, o2_w, o3_w;

   always_comb begin
      if (frame_ff) begin
         o1_w = RW'(x9_ff);
         o2_w = RW'(y9_ff);
         o3_w = RW'(z9_ff);
      end else begin
         o1_w = -rnd_mul(pe1_ff, ne1_ff) + rnd_mul(pe2_ff, ne2s_ff);
         o2_w = -rnd_mul(pn1_ff, nn1_ff) - rnd_mul(pn2_ff, nn2_ff)
                + rnd_mul(pn3_ff, nn3_ff);
         o3_w = rnd_mul(pu1_ff, nu1_ff) + rnd_mul(pu2_ff, nu2_ff)
                + rnd_mul(pu3_ff, nu3_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= v9_ff;
      end
      if (out_load) begin
         rsp_tdata_ff <= {7'b0, sat_out(o3_w), sat_out(o2_w), sat_out(o1_w)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
